[sv/gpc_pkg.sv]
package gpc_pkg;

    // Fixed field widths
    localparam int CFG_W     = 8;
    localparam int PATH_W    = 32;
    localparam int S_TDATA_W = 8;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_COLUMNS = 128;
    localparam int DEF_COUNT_BITS  = 32;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Per-cell flags classified by the front
    typedef struct packed {
        logic first_row;
        logic blocked;
        logic last;
    } gpc_flags_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } gpc_qstat_t;

endpackage

[sv/grid_path_count_with_obstacles.sv]
// Channel   Direction  Ports                        Contents
// cells     in         s_tvalid/s_tready/s_tdata    tdata[0] blocked, tlast last_cell
// results   out        m_tvalid/m_tready/m_tdata    tdata path_count, tuser overflow
// config    in         cfg_wr_en/cfg_wr_data        grid_columns
//
// One cell per clock sustained while the queue has room; the row store does one
// read and one write per cell, and a write-to-read bypass covers a one-column grid.
// After the last cell's transfer its result passes the queue, then the exec stage,
// then the output register, whose valid bit drives m_tvalid.
// Reset clears control only; the row store is not cleared and needs no sweep.
// A stalled result holds the exec stage only on the last cell; the four-entry
// queue keeps taking cells while the back end waits, until it is full.
module grid_path_count_with_obstacles
    import gpc_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [0] blocked, rest zero
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PATH_W-1:0]    m_tdata,   // [31:0] path_count
    output logic                 m_tuser    // [0] overflow
);

    localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ITEM_W = IDX_W + $bits(gpc_flags_t);

    logic             cell_fire;
    logic [IDX_W-1:0] cell_col;
    gpc_flags_t       cell_flags;
    logic [ITEM_W-1:0] head_item;
    logic [IDX_W-1:0] q_col;
    gpc_flags_t       q_flags;
    gpc_qstat_t       q_stat;
    logic             q_pop;
    logic             result_load;

    assign s_tready  = !q_stat.full;
    assign cell_fire = s_tvalid && s_tready;

    // Front: column walk and cell classification
    gpc_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .cell_fire    (cell_fire),
        .cell_blocked (s_tdata[0]),
        .cell_last    (s_tlast),
        .cell_col     (cell_col),
        .cell_flags   (cell_flags)
    );

    // Queue between front and back
    gpc_queue #(
        .W     (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cell_fire),
        .push_data ({cell_flags, cell_col}),
        .pop       (q_pop),
        .head_data (head_item),
        .stat      (q_stat)
    );

    assign q_col   = head_item[IDX_W-1:0];
    assign q_flags = head_item[ITEM_W-1:IDX_W];

    // Back: row store, count update, result register
    gpc_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (!q_stat.empty),
        .q_col       (q_col),
        .q_flags     (q_flags),
        .q_pop       (q_pop),
        .result_load (result_load),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Checks
    a_queue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(result_load))
        else $error("result without a last cell");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("control not cleared by reset");

endmodule

[sv/gpc_ram.sv]
module gpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/gpc_queue.sv]
module gpc_queue
    import gpc_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head_data,
    output gpc_qstat_t   stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Slot storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data  = slot_reg[rd_ptr_reg];
    assign stat.full  = (32'(cnt_reg) == DEPTH);
    assign stat.empty = (cnt_reg == '0);

endmodule

[sv/gpc_front.sv]
module gpc_front
    import gpc_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_W-1:0]          cfg_wr_data,
    input  logic                      cell_fire,
    input  logic                      cell_blocked,
    input  logic                      cell_last,
    output logic [(MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1)-1:0] cell_col,
    output gpc_flags_t                cell_flags
);

    localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CMP_W = ((IDX_W > CFG_W) ? IDX_W : CFG_W) + 1;

    logic [CFG_W-1:0] grid_columns_reg;
    logic [IDX_W-1:0] col_idx_reg, col_idx_next;
    logic             first_row_reg, first_row_next;
    logic [CMP_W-1:0] active_cols;
    logic [CMP_W-1:0] col_wide;
    logic [IDX_W-1:0] col;

    // Column register; the user must write it only while idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_columns_reg <= CFG_W'(1);
        end else if (cfg_wr_en) begin
            grid_columns_reg <= cfg_wr_data;
        end
    end

    // Zero means one column; clamp to the row store depth
    always_comb begin
        if (grid_columns_reg == '0) begin
            active_cols = CMP_W'(1);
        end else if (CMP_W'(grid_columns_reg) > CMP_W'(MAX_COLUMNS)) begin
            active_cols = CMP_W'(MAX_COLUMNS);
        end else begin
            active_cols = CMP_W'(grid_columns_reg);
        end
    end

    // Current column, folded to zero when outside the store
    assign col      = (CMP_W'(col_idx_reg) >= CMP_W'(MAX_COLUMNS)) ? '0 : col_idx_reg;
    assign col_wide = CMP_W'(col) + CMP_W'(1);

    // Row walk: advance column, wrap at row end, restart on last cell
    always_comb begin
        col_idx_next   = col_idx_reg;
        first_row_next = first_row_reg;
        if (cell_fire) begin
            if (cell_last) begin
                col_idx_next   = '0;
                first_row_next = 1'b1;
            end else if (col_wide >= active_cols) begin
                col_idx_next   = '0;
                first_row_next = 1'b0;
            end else begin
                col_idx_next   = IDX_W'(col_wide);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_idx_reg   <= '0;
            first_row_reg <= 1'b1;
        end else begin
            col_idx_reg   <= col_idx_next;
            first_row_reg <= first_row_next;
        end
    end

    assign cell_col             = col;
    assign cell_flags.first_row = first_row_reg;
    assign cell_flags.blocked   = cell_blocked;
    assign cell_flags.last      = cell_last;

endmodule

[sv/gpc_back.sv]
module gpc_back
    import gpc_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  logic [(MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1)-1:0] q_col,
    input  gpc_flags_t        q_flags,
    output logic              q_pop,
    output logic              result_load,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [PATH_W-1:0] m_tdata,
    output logic              m_tuser
);

    localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                  exec_valid_reg, exec_valid_next;
    logic [IDX_W-1:0]      exec_col_reg;
    gpc_flags_t            exec_flags_reg;
    logic                  fwd_valid_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;
    logic [COUNT_BITS-1:0] left_reg;
    logic                  sat_seen_reg, sat_seen_next;
    logic                  out_valid_reg, out_valid_next;
    logic [PATH_W-1:0]     out_count_reg;
    logic                  out_ovf_reg;

    logic [COUNT_BITS-1:0] rd_data;
    logic [COUNT_BITS-1:0] up, left;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] count;
    logic                  sat_now;
    logic                  out_free;
    logic                  exec_adv;

    // Row store: one count per column
    gpc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_row_store (
        .aclk    (aclk),
        .wr_en   (exec_adv),
        .wr_addr (exec_col_reg),
        .wr_data (count),
        .rd_en   (q_pop),
        .rd_addr (q_col),
        .rd_data (rd_data)
    );

    // Cell count: above plus left, saturating; zero when blocked, one at the first cell
    always_comb begin
        up      = exec_flags_reg.first_row ? '0 : (fwd_valid_reg ? fwd_data_reg : rd_data);
        left    = (exec_col_reg != '0) ? left_reg : '0;
        sum     = {1'b0, up} + {1'b0, left};
        sat_now = 1'b0;
        if (exec_flags_reg.blocked) begin
            count = '0;
        end else if (exec_flags_reg.first_row && exec_col_reg == '0) begin
            count = COUNT_BITS'(1);
        end else if (sum[COUNT_BITS]) begin
            count   = COUNT_MAX;
            sat_now = 1'b1;
        end else begin
            count = sum[COUNT_BITS-1:0];
        end
    end

    // Exec stage moves on unless a result has nowhere to go
    assign out_free = !out_valid_reg || m_tready;
    assign exec_adv = exec_valid_reg && (!exec_flags_reg.last || out_free);
    assign q_pop    = q_valid && (!exec_valid_reg || exec_adv);

    always_comb begin
        exec_valid_next = exec_valid_reg;
        if (q_pop) begin
            exec_valid_next = 1'b1;
        end else if (exec_adv) begin
            exec_valid_next = 1'b0;
        end
        sat_seen_next = sat_seen_reg;
        if (exec_adv) begin
            sat_seen_next = exec_flags_reg.last ? 1'b0 : (sat_seen_reg | sat_now);
        end
        out_valid_next = out_valid_reg;
        if (exec_adv && exec_flags_reg.last) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exec_valid_reg <= 1'b0;
            sat_seen_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            left_reg       <= '0;
        end else begin
            exec_valid_reg <= exec_valid_next;
            sat_seen_reg   <= sat_seen_next;
            out_valid_reg  <= out_valid_next;
            if (q_pop) begin
                // Bypass when the cell leaving now writes the column being read
                fwd_valid_reg <= exec_adv && (exec_col_reg == q_col);
            end
            if (exec_adv) begin
                left_reg <= count;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            exec_col_reg   <= q_col;
            exec_flags_reg <= q_flags;
            fwd_data_reg   <= count;
        end
        if (exec_adv && exec_flags_reg.last) begin
            out_count_reg <= PATH_W'(count);
            out_ovf_reg   <= sat_seen_reg | sat_now;
        end
    end

    assign result_load = exec_adv && exec_flags_reg.last;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_count_reg;
    assign m_tuser     = out_ovf_reg;

endmodule

[tb/grid_path_count_with_obstacles_tb.sv]
`timescale 1ns / 1ps

module grid_path_count_with_obstacles_tb;
    import gpc_pkg::*;

    localparam int MAX_COLS       = DEF_MAX_COLUMNS;
    localparam int TIMEOUT_CYCLES = 400000;
    // margin after the last result so the pipe has emptied
    localparam int SETTLE_CYCLES  = 8;
    localparam int SEGMENT_CELLS  = 8;
    localparam int NUM_SEGMENTS   = 12;
    localparam int MAX_REPORTS    = 10;

    // where the last mark falls within a generated grid
    typedef enum int {
        MARK_FINAL,
        MARK_EARLY,
        MARK_NONE
    } mark_style_t;

    typedef struct packed {
        logic [PATH_W-1:0] paths;
        logic              ovf;
    } grid_result_t;

    // Mirror of the path counter: row store, position and saturation state
    class grid_tally;
        logic [PATH_W-1:0] col_counts [MAX_COLS];
        int unsigned       col_idx;
        bit                first_row;
        logic [PATH_W-1:0] left_cnt;
        bit                sat_seen;
        logic [CFG_W-1:0]  grid_cols;
        grid_result_t      due [$];
        int unsigned       mismatches;

        function new();
            for (int i = 0; i < MAX_COLS; i++) col_counts[i] = '0;
            col_idx    = 0;
            first_row  = 1'b1;
            left_cnt   = '0;
            sat_seen   = 1'b0;
            grid_cols  = 8'd1;
            mismatches = 0;
        endfunction

        function void set_columns(logic [CFG_W-1:0] v);
            grid_cols = v;
        endfunction

        // zero means one column, anything above the store size is clamped
        function int unsigned active_cols();
            if (grid_cols == 0) return 1;
            if (grid_cols > MAX_COLS) return MAX_COLS;
            return grid_cols;
        endfunction

        function int unsigned pending();
            return due.size();
        endfunction

        // One accepted cell transfer
        function void take_cell(bit blk, bit lst);
            int unsigned       col;
            logic [PATH_W-1:0] up;
            logic [PATH_W-1:0] left;
            logic [PATH_W-1:0] cnt;
            logic [PATH_W:0]   sum;
            grid_result_t      res;

            col = col_idx;
            if (col >= MAX_COLS) col = 0;
            up   = first_row ? '0 : col_counts[col];
            left = (col > 0) ? left_cnt : '0;

            if (blk) begin
                cnt = '0;
            end else if (first_row && col == 0) begin
                cnt = 1;
            end else begin
                sum = {1'b0, up} + {1'b0, left};
                if (sum[PATH_W]) begin
                    cnt      = '1;
                    sat_seen = 1'b1;
                end else begin
                    cnt = sum[PATH_W-1:0];
                end
            end

            col_counts[col] = cnt;
            left_cnt        = cnt;

            if (lst) begin
                res.paths = cnt;
                res.ovf   = sat_seen;
                due.push_back(res);
                col_idx   = 0;
                first_row = 1'b1;
                left_cnt  = '0;
                sat_seen  = 1'b0;
                return;
            end

            // end of row wraps; also covers a width shrunk below the index
            if (col + 1 >= active_cols()) begin
                col_idx   = 0;
                first_row = 1'b0;
            end else begin
                col_idx = col + 1;
            end
        endfunction

        // One accepted result transfer against the oldest expectation
        function void check_result(logic [PATH_W-1:0] paths, logic ovf);
            grid_result_t want;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with none expected: paths=%0d overflow=%0b",
                             $time, paths, ovf);
                return;
            end
            want = due.pop_front();
            if (paths !== want.paths || ovf !== want.ovf) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: mismatch: expected paths=%0d overflow=%0b, got paths=%0d overflow=%0b",
                             $time, want.paths, want.ovf, paths, ovf);
            end
        endfunction
    endclass

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;   // [0] blocked, rest zero
    logic                 s_tlast     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [PATH_W-1:0]    m_tdata;            // [31:0] path_count
    logic                 m_tuser;            // [0] overflow

    grid_tally   tally = new();
    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    int unsigned cycle_count   = 0;

    grid_path_count_with_obstacles u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Result side: check each transfer, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tally.check_result(m_tdata, m_tuser);
        end
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present one cell, maybe after a random gap, and wait for its transfer
    task automatic send_cell(input bit blk, input bit lst);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < src_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, blk};
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tally.take_cell(blk, lst);
    endtask

    // Stop sending until all results are in and the pipe has emptied
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tally.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_columns(input logic [CFG_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tally.set_columns(v);
    endtask

    // Random-content grid; returns the number of cells sent
    task automatic send_grid(input int unsigned cols, input int unsigned rows,
                             input int unsigned blk_pct, input mark_style_t style,
                             output int unsigned sent);
        int unsigned total;
        int unsigned mark_at;
        bit          lst;
        total = cols * rows;
        case (style)
            MARK_FINAL: mark_at = total - 1;
            MARK_EARLY: mark_at = $urandom_range(0, total - 1);
            default:    mark_at = total;
        endcase
        sent = 0;
        for (int unsigned i = 0; i < total; i++) begin
            lst = (i == mark_at);
            send_cell($urandom_range(0, 99) < blk_pct, lst);
            sent++;
            if (lst) break;
        end
    endtask

    initial begin
        logic [CFG_W-1:0] cfg_val;
        int unsigned      cols;
        int unsigned      rows;
        int unsigned      sent;
        int unsigned      seg_cells;
        int unsigned      pick;
        mark_style_t      style;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset width is one column; open and blocked single cells
        src_idle_pct  = 18;
        sink_idle_pct = 56;
        send_cell(1'b0, 1'b1);
        send_cell(1'b1, 1'b1);

        // width zero acts as one column
        drain();
        write_columns(8'd0);
        send_cell(1'b0, 1'b0);
        send_cell(1'b0, 1'b0);
        send_cell(1'b0, 1'b1);

        // 3x3 with the center blocked: two paths
        drain();
        write_columns(8'd3);
        for (int i = 0; i < 9; i++) send_cell(i == 4, i == 8);

        // last mark early in the first row
        send_cell(1'b0, 1'b0);
        send_cell(1'b0, 1'b1);

        // width shrunk mid-grid below the current column
        drain();
        write_columns(8'd4);
        for (int i = 0; i < 6; i++) send_cell(1'b0, 1'b0);
        drain();
        write_columns(8'd2);
        send_cell(1'b0, 1'b0);
        send_cell(1'b0, 1'b0);
        send_cell(1'b0, 1'b1);

        // open 19x19 grid overflows the count
        drain();
        write_columns(8'd19);
        for (int i = 0; i < 19 * 19; i++) send_cell(1'b0, i == 19 * 19 - 1);

        // Random segments, each with its own width
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            drain();
            if (seg < 4) begin
                src_idle_pct  = 18;
                sink_idle_pct = 56;
            end else if (seg < 8) begin
                src_idle_pct  = 56;
                sink_idle_pct = 18;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            case (seg)
                0:       cfg_val = 8'd1;
                1:       cfg_val = 8'd128;
                2:       cfg_val = 8'd5;
                3:       cfg_val = 8'd0;
                4:       cfg_val = 8'd255;
                5:       cfg_val = 8'd2;
                6:       cfg_val = 8'd129;
                default: cfg_val = CFG_W'($urandom_range(1, 16));
            endcase
            write_columns(cfg_val);
            cols = tally.active_cols();

            seg_cells = 0;
            while (seg_cells < SEGMENT_CELLS) begin
                rows = $urandom_range(1, (cols >= 40) ? 1 : 40 / cols);
                pick = $urandom_range(0, 9);
                style = (pick == 0) ? MARK_EARLY : (pick == 1) ? MARK_NONE : MARK_FINAL;
                case ($urandom_range(0, 3))
                    0:       pick = 0;
                    1:       pick = 10;
                    2:       pick = 25;
                    default: pick = 50;
                endcase
                send_grid(cols, rows, pick, style, sent);
                seg_cells += sent;
            end
            // close any grid left open so the next width starts clean
            send_cell($urandom_range(0, 1), 1'b1);
        end

        drain();
        if (tally.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
sv/gpc_pkg.sv
sv/gpc_ram.sv
sv/gpc_queue.sv
sv/gpc_front.sv
sv/gpc_back.sv
sv/grid_path_count_with_obstacles.sv
tb/grid_path_count_with_obstacles_tb.sv
